### design/isvm_pkg.sv
`default_nettype none

package isvm_pkg;

    // Lane layout: three normal components first, then three shear components.
    localparam int LANES      = 6;
    localparam int NORMALS    = 3;

    // Port widths.
    localparam int STRAIN_W   = 32;
    localparam int STRESS_W   = 48;
    localparam int E_W        = 20;
    localparam int NU_W       = 15;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 20;

    // Internal widths of the constitutive stage and the divider.
    localparam int ONE_W      = 17;
    localparam int PROD_W     = 50;
    localparam int MAG_W      = 49;
    localparam int SPLIT      = 25;
    localparam int NUM_W      = 71;
    localparam int DIV_W      = 34;

    localparam int ROOT_BITS_DEFAULT = 48;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_YOUNG   = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_POISSON = 8'd1;

    localparam logic [E_W-1:0]   YOUNG_RESET   = 20'd200000;
    localparam logic [NU_W-1:0]  POISSON_RESET = 15'd19661;
    localparam logic [ONE_W-1:0] ONE_Q16       = 17'h10000;

    typedef logic [STRAIN_W-1:0] strain_t;
    typedef logic [STRESS_W-1:0] stress_t;
    typedef logic [NUM_W-1:0]    num_t;
    typedef logic [DIV_W-1:0]    divisor_t;

    // Doubled divisors: normal lanes and shear lanes.
    typedef struct packed {
        divisor_t nrm;
        divisor_t shr;
    } divisors_t;

    // Rounding numerators with their signs, one per lane.
    typedef struct packed {
        num_t [LANES-1:0]  num;
        logic [LANES-1:0]  neg;
    } hk_beat_t;

    // Saturated stresses and the combined saturation flag.
    typedef struct packed {
        stress_t [LANES-1:0] s;
        logic                ovf;
    } st_beat_t;

endpackage

`default_nettype wire

### design/isotropic_stress_von_mises.sv
`default_nettype none

// Channel  Handshake               Payload
// in       in_valid / in_ready     strain_xx..strain_zz, shear_xy..shear_zx
// out      out_valid / out_ready   stress_xx..stress_zz, tau_xy..tau_zx,
//                                  equivalent_stress, overflow
// cfg      cfg_valid / cfg_ready   cfg_addr, cfg_data
//
// One beat enters per cycle while in_ready is high; the pipe holds the 48 one-bit
// divider stages per lane and the one-bit-per-stage square root.
// Reset clears the valid bits and loads E = 200000 MPa and nu = 19661 / 65536.
// Each of the three sections moves as a whole: it holds while its last beat is not
// taken, and one whose last stage is empty keeps moving.
// Configuration writes are taken every cycle and belong where the pipe is empty.

module isotropic_stress_von_mises #(
    parameter int ROOT_BITS = isvm_pkg::ROOT_BITS_DEFAULT
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     in_valid,
    output logic                                          in_ready,
    input  wire logic signed [isvm_pkg::STRAIN_W-1:0]     strain_xx,
    input  wire logic signed [isvm_pkg::STRAIN_W-1:0]     strain_yy,
    input  wire logic signed [isvm_pkg::STRAIN_W-1:0]     strain_zz,
    input  wire logic signed [isvm_pkg::STRAIN_W-1:0]     shear_xy,
    input  wire logic signed [isvm_pkg::STRAIN_W-1:0]     shear_yz,
    input  wire logic signed [isvm_pkg::STRAIN_W-1:0]     shear_zx,
    output logic                                          out_valid,
    input  wire logic                                     out_ready,
    output logic signed [isvm_pkg::STRESS_W-1:0]          stress_xx,
    output logic signed [isvm_pkg::STRESS_W-1:0]          stress_yy,
    output logic signed [isvm_pkg::STRESS_W-1:0]          stress_zz,
    output logic signed [isvm_pkg::STRESS_W-1:0]          tau_xy,
    output logic signed [isvm_pkg::STRESS_W-1:0]          tau_yz,
    output logic signed [isvm_pkg::STRESS_W-1:0]          tau_zx,
    output logic [isvm_pkg::STRESS_W-1:0]                 equivalent_stress,
    output logic                                          overflow,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [isvm_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  wire logic [isvm_pkg::CFG_DATA_W-1:0]          cfg_data
);

    import isvm_pkg::*;

    logic [E_W-1:0]        young_reg;
    logic [NU_W-1:0]       poisson_reg;
    logic [ONE_W-1:0]      nplus;
    logic [ONE_W-1:0]      nminus;
    logic [2*ONE_W-1:0]    dn;
    divisors_t             dvs_next;
    divisors_t             dvs_reg;
    strain_t [LANES-1:0]   strain;
    logic                  hk_valid;
    logic                  hk_ready;
    hk_beat_t              hk_beat;
    logic                  st_valid;
    logic                  st_ready;
    st_beat_t              st_beat;
    st_beat_t              fin_beat;

    // Register writes; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            young_reg   <= YOUNG_RESET;
            poisson_reg <= POISSON_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_YOUNG:   young_reg   <= cfg_data[E_W-1:0];
                REG_POISSON: poisson_reg <= cfg_data[NU_W-1:0];
                default:     ;
            endcase
        end
    end

    // Doubled divisors: 2(1+nu)(1-2nu) in Q32 for normals, 4(1+nu) in Q16 for shear.
    assign nplus         = ONE_Q16 + ONE_W'(poisson_reg);
    assign nminus        = ONE_Q16 - ONE_W'({poisson_reg, 1'b0});
    assign dn            = (2*ONE_W)'(nplus) * (2*ONE_W)'(nminus);
    assign dvs_next.nrm  = DIV_W'({dn, 1'b0});
    assign dvs_next.shr  = DIV_W'({nplus, 2'b00});

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
    end

    assign strain[0] = strain_xx;
    assign strain[1] = strain_yy;
    assign strain[2] = strain_zz;
    assign strain[3] = shear_xy;
    assign strain[4] = shear_yz;
    assign strain[5] = shear_zx;

    isvm_hooke u_hooke (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .strain    (strain),
        .young     (young_reg),
        .poisson   (poisson_reg),
        .divisors  (dvs_reg),
        .out_valid (hk_valid),
        .out_ready (hk_ready),
        .out_beat  (hk_beat)
    );

    isvm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hk_valid),
        .in_ready  (hk_ready),
        .in_beat   (hk_beat),
        .divisors  (dvs_reg),
        .out_valid (st_valid),
        .out_ready (st_ready),
        .out_beat  (st_beat)
    );

    isvm_vm #(.ROOT_BITS(ROOT_BITS)) u_vm (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (st_valid),
        .in_ready   (st_ready),
        .in_beat    (st_beat),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_beat   (fin_beat),
        .equivalent (equivalent_stress),
        .overflow   (overflow)
    );

    assign stress_xx = $signed(fin_beat.s[0]);
    assign stress_yy = $signed(fin_beat.s[1]);
    assign stress_zz = $signed(fin_beat.s[2]);
    assign tau_xy    = $signed(fin_beat.s[3]);
    assign tau_yz    = $signed(fin_beat.s[4]);
    assign tau_zx    = $signed(fin_beat.s[5]);

endmodule

`default_nettype wire

### design/isvm_flow.sv
`default_nettype none

module isvm_flow #(
    parameter int STAGES = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output logic      en
);

    logic [STAGES-1:0] vld_reg;

    // The whole pipe moves when the last stage is empty or is being taken.
    assign en        = out_ready || !vld_reg[STAGES-1];
    assign in_ready  = en;
    assign out_valid = vld_reg[STAGES-1];

    // Valid bits shift along with the data registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipe with an empty last stage refused a beat");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted beat did not reach the first stage");

endmodule

`default_nettype wire

### design/isvm_hooke.sv
`default_nettype none

module isvm_hooke (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,
    input  wire logic                                       in_valid,
    output logic                                            in_ready,
    input  wire isvm_pkg::strain_t [isvm_pkg::LANES-1:0]    strain,
    input  wire logic [isvm_pkg::E_W-1:0]                   young,
    input  wire logic [isvm_pkg::NU_W-1:0]                  poisson,
    input  wire isvm_pkg::divisors_t                        divisors,
    output logic                                            out_valid,
    input  wire logic                                       out_ready,
    output isvm_pkg::hk_beat_t                              out_beat
);

    import isvm_pkg::*;

    localparam int S    = 4;
    localparam int PL_W = E_W + SPLIT;
    localparam int PH_W = E_W + MAG_W - SPLIT;

    logic             en;
    logic [ONE_W-1:0] w;

    isvm_flow #(.STAGES(S)) u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    // Weight of the own normal strain: one minus the ratio, in Q16.
    assign w = ONE_Q16 - ONE_W'(poisson);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [PROD_W-1:0] p1_next;
        logic signed [PROD_W-1:0] p2_next;
        logic signed [PROD_W-1:0] p1_reg;
        logic signed [PROD_W-1:0] p2_reg;
        logic signed [PROD_W-1:0] a;
        logic        [PROD_W-1:0] a_u;
        logic        [PROD_W-1:0] a_abs;
        logic        [MAG_W-1:0]  mag_reg;
        logic                     neg1_reg;
        logic                     neg2_reg;
        logic                     neg3_reg;
        logic        [PL_W-1:0]   pl_reg;
        logic        [PH_W-1:0]   ph_reg;
        logic        [NUM_W-1:0]  prod;
        logic        [NUM_W-1:0]  num_next;
        logic        [NUM_W-1:0]  num_reg;
        divisor_t                 d2;

        // Weighted strain sums for normal lanes, plain shear strain otherwise.
        if (l < NORMALS)
        begin : g_normal
            localparam int J = (l + 1) % NORMALS;
            localparam int K = (l + 2) % NORMALS;
            logic signed [STRAIN_W:0] side;

            assign side    = (STRAIN_W+1)'($signed(strain[J]))
                           + (STRAIN_W+1)'($signed(strain[K]));
            assign p1_next = PROD_W'($signed({1'b0, w})) * PROD_W'($signed(strain[l]));
            assign p2_next = PROD_W'($signed({1'b0, poisson})) * PROD_W'(side);
            assign d2      = divisors.nrm;
        end
        else
        begin : g_shear
            assign p1_next = PROD_W'($signed(strain[l]));
            assign p2_next = '0;
            assign d2      = divisors.shr;
        end

        // Sum and sign-magnitude split.
        assign a     = p1_reg + p2_reg;
        assign a_u   = a;
        assign a_abs = a_u[PROD_W-1] ? (~a_u + PROD_W'(1)) : a_u;

        // Numerator of the rounded quotient: 2*E*|a| + d.
        assign prod     = (NUM_W'(ph_reg) << SPLIT) + NUM_W'(pl_reg);
        assign num_next = (prod << 1) + NUM_W'(d2 >> 1);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p1_reg   <= p1_next;
                p2_reg   <= p2_next;
                mag_reg  <= a_abs[MAG_W-1:0];
                neg1_reg <= a_u[PROD_W-1];
                pl_reg   <= PL_W'(young) * PL_W'(mag_reg[SPLIT-1:0]);
                ph_reg   <= PH_W'(young) * PH_W'(mag_reg[MAG_W-1:SPLIT]);
                neg2_reg <= neg1_reg;
                num_reg  <= num_next;
                neg3_reg <= neg2_reg;
            end
        end

        assign out_beat.num[l] = num_reg;
        assign out_beat.neg[l] = neg3_reg;
    end

endmodule

`default_nettype wire

### design/isvm_div.sv
`default_nettype none

module isvm_div (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire isvm_pkg::hk_beat_t    in_beat,
    input  wire isvm_pkg::divisors_t   divisors,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output isvm_pkg::st_beat_t         out_beat
);

    import isvm_pkg::*;

    localparam int QB   = STRESS_W;
    localparam int HI_W = NUM_W - QB;
    localparam int S    = QB + 2;

    localparam logic [QB-1:0] POS_LIM = {1'b0, {(QB-1){1'b1}}};
    localparam logic [QB-1:0] NEG_LIM = {1'b1, {(QB-1){1'b0}}};

    logic             en;
    logic [LANES-1:0] sat_reg;

    isvm_flow #(.STAGES(S)) u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        divisor_t         d2;
        logic [HI_W-1:0]  hi;
        logic [DIV_W-1:0] rem_reg [QB];
        logic [QB-1:0]    low_reg [QB];
        logic [QB-1:0]    q_reg   [QB+1];
        logic             neg_reg [QB+1];
        logic             big_reg [QB+1];
        logic [QB-1:0]    q_fin;
        logic             sat;
        stress_t          s_reg;

        if (l < NORMALS)
        begin : g_nrm
            assign d2 = divisors.nrm;
        end
        else
        begin : g_shr
            assign d2 = divisors.shr;
        end

        // Entry: a quotient of 2^48 or more saturates in any case.
        assign hi = in_beat.num[l][NUM_W-1:QB];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[0] <= DIV_W'(hi);
                low_reg[0] <= in_beat.num[l][QB-1:0];
                q_reg[0]   <= '0;
                neg_reg[0] <= in_beat.neg[l];
                big_reg[0] <= (DIV_W'(hi) >= d2);
            end
        end

        // One restoring quotient bit per stage.
        for (genvar j = 1; j <= QB; j++)
        begin : g_step
            logic [DIV_W:0]   r2;
            logic             ge;
            logic [DIV_W:0]   diff;

            assign r2   = {rem_reg[j-1], low_reg[j-1][QB-1]};
            assign ge   = (r2 >= {1'b0, d2});
            assign diff = r2 - {1'b0, d2};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    q_reg[j]   <= {q_reg[j-1][QB-2:0], ge};
                    neg_reg[j] <= neg_reg[j-1];
                    big_reg[j] <= big_reg[j-1];
                end
            end

            if (j < QB)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[j] <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
                        low_reg[j] <= low_reg[j-1] << 1;
                    end
                end
            end
        end

        // Saturate against the limit of the sign and apply the sign.
        assign q_fin = q_reg[QB];
        assign sat   = big_reg[QB] || (neg_reg[QB] ? (q_fin > NEG_LIM) : (q_fin > POS_LIM));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sat_reg[l] <= sat;
                if (sat)
                begin
                    s_reg <= neg_reg[QB] ? NEG_LIM : POS_LIM;
                end
                else
                begin
                    s_reg <= neg_reg[QB] ? (~q_fin + QB'(1)) : q_fin;
                end
            end
        end

        assign out_beat.s[l] = s_reg;
    end

    assign out_beat.ovf = |sat_reg;

endmodule

`default_nettype wire

### design/isvm_vm.sv
`default_nettype none

module isvm_vm #(
    parameter int ROOT_BITS = isvm_pkg::ROOT_BITS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire isvm_pkg::st_beat_t                in_beat,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output isvm_pkg::st_beat_t                     out_beat,
    output logic [isvm_pkg::STRESS_W-1:0]          equivalent,
    output logic                                   overflow
);

    import isvm_pkg::*;

    localparam int LB     = (ROOT_BITS < STRESS_W) ? ROOT_BITS : STRESS_W;
    localparam int HALF   = STRESS_W / 2;
    localparam int PP_W   = 2 * HALF;
    localparam int SQ_W   = 2 * STRESS_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int TOT_W  = SUM_W + 2;
    localparam int RADV_W = TOT_W - 1;
    localparam int RAD_W  = 2 * LB;
    localparam int RM_W   = LB + 2;
    localparam int S      = 5 + LB + 1;

    logic                en;
    st_beat_t            sb_reg [S];
    logic [STRESS_W-1:0] mag_reg [LANES];
    logic [SQ_W-1:0]     sq_reg  [LANES];
    logic [SUM_W-1:0]    sa_reg;
    logic [SUM_W-1:0]    sb_sum_reg;
    logic [TOT_W-1:0]    tot;
    logic [RADV_W-1:0]   v;
    logic [RAD_W-1:0]    rad_reg  [LB];
    logic [RM_W-1:0]     rem_reg  [LB];
    logic [LB-1:0]       root_reg [LB+1];
    logic                rovf_reg [LB+1];
    logic [STRESS_W-1:0] eq_reg;
    logic                ovf_reg;

    isvm_flow #(.STAGES(S)) u_flow (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .en        (en)
    );

    // The stresses travel beside the root datapath.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= in_beat;
        end
    end

    for (genvar k = 1; k < S; k++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[k] <= sb_reg[k-1];
            end
        end
    end

    // Magnitudes of normal differences and shear stresses, then their squares.
    for (genvar l = 0; l < LANES; l++)
    begin : g_sq
        logic signed [STRESS_W:0] dif;
        logic        [STRESS_W:0] dif_u;
        logic        [STRESS_W:0] dif_abs;
        logic [PP_W-1:0]          hh_reg;
        logic [PP_W-1:0]          hl_reg;
        logic [PP_W-1:0]          ll_reg;

        if (l < NORMALS)
        begin : g_dif
            localparam int J = (l + 1) % NORMALS;
            assign dif = (STRESS_W+1)'($signed(in_beat.s[l]))
                       - (STRESS_W+1)'($signed(in_beat.s[J]));
        end
        else
        begin : g_tau
            assign dif = (STRESS_W+1)'($signed(in_beat.s[l]));
        end

        assign dif_u   = dif;
        assign dif_abs = dif_u[STRESS_W] ? (~dif_u + (STRESS_W+1)'(1)) : dif_u;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[l] <= dif_abs[STRESS_W-1:0];
                hh_reg     <= PP_W'(mag_reg[l][STRESS_W-1:HALF])
                            * PP_W'(mag_reg[l][STRESS_W-1:HALF]);
                hl_reg     <= PP_W'(mag_reg[l][STRESS_W-1:HALF])
                            * PP_W'(mag_reg[l][HALF-1:0]);
                ll_reg     <= PP_W'(mag_reg[l][HALF-1:0]) * PP_W'(mag_reg[l][HALF-1:0]);
                sq_reg[l]  <= (SQ_W'(hh_reg) << STRESS_W) + (SQ_W'(hl_reg) << (HALF + 1))
                            + SQ_W'(ll_reg);
            end
        end
    end

    // Sum of squares with the shear terms weighted by six, then halved.
    assign tot = TOT_W'(sa_reg) + (TOT_W'(sb_sum_reg) << 2) + (TOT_W'(sb_sum_reg) << 1);
    assign v   = tot[TOT_W-1:1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg      <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sb_sum_reg  <= SUM_W'(sq_reg[3]) + SUM_W'(sq_reg[4]) + SUM_W'(sq_reg[5]);
            rad_reg[0]  <= v[RAD_W-1:0];
            rovf_reg[0] <= |v[RADV_W-1:RAD_W];
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // Integer square root, one result bit per stage.
    for (genvar r = 0; r < LB; r++)
    begin : g_root
        logic [RM_W+1:0] rem2;
        logic [RM_W+1:0] trial;
        logic [RM_W+1:0] diff;
        logic            ge;

        assign rem2  = {rem_reg[r], rad_reg[r][RAD_W-1:RAD_W-2]};
        assign trial = (RM_W+2)'({root_reg[r], 2'b01});
        assign ge    = (rem2 >= trial);
        assign diff  = rem2 - trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[r+1] <= {root_reg[r][LB-2:0], ge};
                rovf_reg[r+1] <= rovf_reg[r];
            end
        end

        if (r + 1 < LB)
        begin : g_next
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[r+1] <= ge ? diff[RM_W-1:0] : rem2[RM_W-1:0];
                    rad_reg[r+1] <= rad_reg[r] << 2;
                end
            end
        end
    end

    // Output register: saturate the root and merge the flags.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eq_reg  <= rovf_reg[LB] ? STRESS_W'({LB{1'b1}}) : STRESS_W'(root_reg[LB]);
            ovf_reg <= sb_reg[S-2].ovf | rovf_reg[LB];
        end
    end

    assign out_beat   = sb_reg[S-1];
    assign equivalent = eq_reg;
    assign overflow   = ovf_reg;

    a_root_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((equivalent >> LB) == '0))
        else $error("equivalent stress wider than the root");

endmodule

`default_nettype wire
